[sv/srps_pkg.sv]
// Shared types, constants and codes for the seeded random position sampler.
// No dependencies; every other design file but srps_stream_if imports this package.
package srps_pkg;

    // Mix constants
    localparam logic [63:0] GOLDEN_ADD = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;

    // Region seed constants
    localparam logic [63:0] TICK_MUL   = 64'hD1B54A32D192ED03;
    localparam logic [63:0] CX_MUL     = 64'h9E3779B185EBCA87;
    localparam logic [63:0] CZ_MUL     = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] SY_MUL     = 64'h165667B19E3779F9;

    localparam int SUB_CHUNKS_DEF = 16;
    localparam int SUB_CHUNKS_W   = 9;

    // Configuration port
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 64;
    localparam int REG_IDX_LSB = 3;
    localparam logic [APB_ADDR_W-REG_IDX_LSB-1:0] REG_WORLD_SEED = '0;

    // Item kinds
    localparam logic [1:0] KIND_RESEED = 2'd0;
    localparam logic [1:0] KIND_POS    = 2'd1;
    localparam logic [1:0] KIND_WORD   = 2'd2;

    // Result kinds
    localparam logic RES_POS  = 1'b0;
    localparam logic RES_WORD = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [63:0]        tick_index;
        logic signed [31:0] chunk_x;
        logic signed [31:0] chunk_z;
        logic [3:0]         sub_chunk_y;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [3:0]  local_x;
        logic [3:0]  local_y;
        logic [3:0]  local_z;
        logic [31:0] random_word;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEED_MUL,
        S_MIX_PRE,
        S_MUL_A,
        S_MUL_B,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        MOP_TICK,
        MOP_CX,
        MOP_CZ,
        MOP_SY,
        MOP_MIXA,
        MOP_MIXB
    } mul_op_t;

    // Multiplier phases: one partial product per phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOHI,
        PH_HILO,
        PH_DONE
    } mul_phase_t;

    typedef struct packed {
        logic    cap_in;
        logic    acc_init;
        logic    acc_xor;
        logic    mul_start;
        mul_op_t mul_op;
        logic    work_pre;
        logic    mix_src_acc;
        logic    work_mid;
        logic    state_load;
        logic    cell_load;
        logic    cell_idx;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       sy_ok;
        logic       mul_done;
    } status_t;

endpackage

[sv/srps_stream_if.sv]
// Valid/ready stream channel with a typed payload.
// Depends on nothing; the payload type is set where the channel is instantiated.
interface srps_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/srps_mul.sv]
// 64x64 multiplier, low 64 bits of the product, built from one 32x32 multiplier
// over three partial products. Depends on srps_pkg; operands must hold until done.
module srps_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] product
);
    import srps_pkg::*;

    mul_phase_t  phase_reg;
    mul_phase_t  phase_next;
    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] pp_next;
    logic [63:0] pp_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;

    // Pick the partial product for this phase
    always_comb
    begin
        case (phase_reg)
            PH_LOHI:
            begin
                mx = a[31:0];
                my = b[63:32];
            end
            PH_HILO:
            begin
                mx = a[63:32];
                my = b[31:0];
            end
            default:
            begin
                mx = a[31:0];
                my = b[31:0];
            end
        endcase
    end

    assign pp_next = 64'(mx) * 64'(my);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = PH_LOHI;
                end
            end
            PH_LOHI:
            begin
                acc_next   = pp_reg;
                phase_next = PH_HILO;
            end
            PH_HILO:
            begin
                acc_next   = acc_reg + {pp_reg[31:0], 32'd0};
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg  <= pp_next;
        acc_reg <= acc_next;
    end

    assign done    = (phase_reg == PH_DONE);
    assign product = acc_reg + {pp_reg[31:0], 32'd0};

endmodule

[sv/srps_dp.sv]
// Datapath: world seed register and its bus port, captured item, region seed
// accumulator, mix work register, generator state, cells and result register.
// Depends on srps_pkg and srps_mul.
module srps_dp #(
    parameter int SUB_CHUNKS = srps_pkg::SUB_CHUNKS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  srps_pkg::cmd_t                             cmd,
    output srps_pkg::status_t                          status,
    input  srps_pkg::in_item_t                         in_payload,
    output srps_pkg::out_item_t                        out_payload,
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [srps_pkg::APB_ADDR_W-1:0]            paddr,
    input  logic [srps_pkg::APB_DATA_W-1:0]            pwdata,
    output logic [srps_pkg::APB_DATA_W-1:0]            prdata
);
    import srps_pkg::*;

    logic [63:0]        world_seed_reg;
    logic [63:0]        gen_state_reg;
    logic [1:0]         kind_reg;
    logic [63:0]        tick_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cz_reg;
    logic [3:0]         sy_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        work_reg;
    logic [3:0]         cell_reg [2];
    out_item_t          out_reg;

    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic        mul_done;
    logic [63:0] prod;
    logic [63:0] pre_sum;
    logic [63:0] mixed;
    logic        reg_hit;

    // Configuration register
    assign reg_hit = (paddr[APB_ADDR_W-1:REG_IDX_LSB] == REG_WORLD_SEED);
    assign prdata  = reg_hit ? world_seed_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_seed_reg <= '0;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            world_seed_reg <= pwdata;
        end
    end

    // Multiplier operand select
    always_comb
    begin
        case (cmd.mul_op)
            MOP_TICK:
            begin
                mul_a = tick_reg;
                mul_b = TICK_MUL;
            end
            MOP_CX:
            begin
                mul_a = {32'd0, cx_reg};
                mul_b = CX_MUL;
            end
            MOP_CZ:
            begin
                mul_a = {32'd0, cz_reg};
                mul_b = CZ_MUL;
            end
            MOP_SY:
            begin
                mul_a = {60'd0, sy_reg};
                mul_b = SY_MUL;
            end
            MOP_MIXB:
            begin
                mul_a = work_reg;
                mul_b = MIX_MUL_B;
            end
            default:
            begin
                mul_a = work_reg;
                mul_b = MIX_MUL_A;
            end
        endcase
    end

    srps_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (prod)
    );

    assign pre_sum = (cmd.mix_src_acc ? acc_reg : gen_state_reg) + GOLDEN_ADD;
    assign mixed   = prod ^ (prod >> 31);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_state_reg <= '0;
        end
        else if (cmd.state_load)
        begin
            gen_state_reg <= mixed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            kind_reg <= in_payload.kind;
            tick_reg <= in_payload.tick_index;
            cx_reg   <= in_payload.chunk_x;
            cz_reg   <= in_payload.chunk_z;
            sy_reg   <= in_payload.sub_chunk_y;
        end
        if (cmd.acc_init)
        begin
            acc_reg <= world_seed_reg;
        end
        else if (cmd.acc_xor)
        begin
            acc_reg <= acc_reg ^ prod;
        end
        if (cmd.work_pre)
        begin
            work_reg <= pre_sum ^ (pre_sum >> 30);
        end
        else if (cmd.work_mid)
        begin
            work_reg <= prod ^ (prod >> 27);
        end
        if (cmd.cell_load)
        begin
            cell_reg[cmd.cell_idx] <= mixed[35:32];
        end
        if (cmd.out_load)
        begin
            if (kind_reg == KIND_WORD)
            begin
                out_reg.result_kind <= RES_WORD;
                out_reg.local_x     <= '0;
                out_reg.local_y     <= '0;
                out_reg.local_z     <= '0;
                out_reg.random_word <= gen_state_reg[63:32];
            end
            else
            begin
                // Third draw sits in the generator state
                out_reg.result_kind <= RES_POS;
                out_reg.local_x     <= cell_reg[0];
                out_reg.local_y     <= cell_reg[1];
                out_reg.local_z     <= gen_state_reg[35:32];
                out_reg.random_word <= '0;
            end
        end
    end

    assign out_payload     = out_reg;
    assign status.kind     = kind_reg;
    assign status.sy_ok    = ({{(SUB_CHUNKS_W-4){1'b0}}, sy_reg} < SUB_CHUNKS_W'(SUB_CHUNKS));
    assign status.mul_done = mul_done;

endmodule

[sv/srps_ctrl.sv]
// Controller: sequences reseed, mix and draw steps of the datapath and owns
// the channel handshakes. Depends on srps_pkg.
module srps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  srps_pkg::status_t status,
    output srps_pkg::cmd_t    cmd
);
    import srps_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] term_reg;
    logic [1:0] term_next;
    logic [1:0] draw_reg;
    logic [1:0] draw_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd        = '0;
        cmd.mul_op = MOP_MIXA;
        in_ready   = 1'b0;
        state_next = state_reg;
        term_next  = term_reg;
        draw_next  = draw_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap_in = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.kind)
                    KIND_RESEED:
                    begin
                        if (status.sy_ok)
                        begin
                            cmd.acc_init = 1'b1;
                            term_next    = 2'd0;
                            state_next   = S_SEED_MUL;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    KIND_POS, KIND_WORD:
                    begin
                        draw_next  = 2'd0;
                        state_next = S_MIX_PRE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SEED_MUL:
            begin
                cmd.mul_start = 1'b1;
                case (term_reg)
                    2'd0:    cmd.mul_op = MOP_TICK;
                    2'd1:    cmd.mul_op = MOP_CX;
                    2'd2:    cmd.mul_op = MOP_CZ;
                    default: cmd.mul_op = MOP_SY;
                endcase
                if (status.mul_done)
                begin
                    cmd.acc_xor = 1'b1;
                    if (term_reg == 2'd3)
                    begin
                        state_next = S_MIX_PRE;
                    end
                    else
                    begin
                        term_next = term_reg + 2'd1;
                    end
                end
            end
            S_MIX_PRE:
            begin
                cmd.work_pre    = 1'b1;
                cmd.mix_src_acc = (status.kind == KIND_RESEED);
                state_next      = S_MUL_A;
            end
            S_MUL_A:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = MOP_MIXA;
                if (status.mul_done)
                begin
                    cmd.work_mid = 1'b1;
                    state_next   = S_MUL_B;
                end
            end
            S_MUL_B:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = MOP_MIXB;
                if (status.mul_done)
                begin
                    cmd.state_load = 1'b1;
                    cmd.cell_load  = (status.kind == KIND_POS) && (draw_reg != 2'd2);
                    cmd.cell_idx   = draw_reg[0];
                    if (status.kind == KIND_RESEED)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (status.kind == KIND_POS && draw_reg != 2'd2)
                    begin
                        draw_next  = draw_reg + 2'd1;
                        state_next = S_MIX_PRE;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                // Wait for the result register to drain
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            term_reg      <= '0;
            draw_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            term_reg      <= term_next;
            draw_reg      <= draw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == S_DECODE)
        else $error("accepted item not decoded next cycle");

    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before transfer");

    a_state_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.state_load |-> (state_reg == S_MUL_B && status.mul_done))
        else $error("generator state loaded without finished product");

    a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside output step");

endmodule

[sv/seeded_random_position_sampler.sv]
// Top level of the seeded random position sampler: controller plus datapath.
// Depends on srps_pkg, srps_stream_if, srps_ctrl and srps_dp.
//
// Usage:
//   in_ch carries items (kind, tick_index, chunk_x, chunk_z, sub_chunk_y);
//   out_ch carries results (result_kind, local_x/y/z, random_word). Both are
//   valid/ready channels; a transfer happens when valid and ready are high.
//   The APB port writes/reads world_seed at byte address 0 (64-bit data);
//   pready is always high. Write it only while the block is idle.
// Sequencing: one item at a time. Each mix is bounded by the single 32x32
//   multiplier (three partial products per 64-bit multiply, two multiplies
//   per mix). A reseed runs four seed multiplies plus one mix and gives no
//   result; a word item runs one mix to its result, a position item three
//   mixes. Unknown kinds and out-of-range sub_chunk_y are dropped.
// The result register decouples the sides: a new item is taken while a result
//   waits; if the receiver stalls, the next result waits with the controller in
//   S_OUT until the register drains.
// Reset clears the generator state and world_seed to zero.
module seeded_random_position_sampler #(
    parameter int SUB_CHUNKS = srps_pkg::SUB_CHUNKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    srps_stream_if.sink                     in_ch,
    srps_stream_if.source                   out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [srps_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [srps_pkg::APB_DATA_W-1:0] pwdata,
    output logic [srps_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import srps_pkg::*;

    cmd_t      cmd;
    status_t   status;
    in_item_t  in_payload;
    out_item_t out_payload;
    logic      in_ready;
    logic      out_valid;

    assign pready        = 1'b1;
    assign in_payload    = in_ch.payload;
    assign in_ch.ready   = in_ready;
    assign out_ch.valid  = out_valid;
    assign out_ch.payload = out_payload;

    srps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    srps_dp #(
        .SUB_CHUNKS (SUB_CHUNKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_payload  (in_payload),
        .out_payload (out_payload),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata)
    );

endmodule

[tb/sv/srps_tb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the seeded random position sampler: tracks world_seed and the
// generator state, predicts each draw and checks results in order. Needs srps_pkg.
package srps_tb_pkg;
    import srps_pkg::*;

    // Item kind the block must drop, and a register index with nothing behind it
    localparam logic [1:0]  KIND_UNDEF   = 2'd3;
    localparam int unsigned REG_UNMAPPED = 1;

    class cell_draw_tracker;
        logic [63:0] world_seed;
        logic [63:0] gen_state;
        out_item_t   pending_draws[$];
        int unsigned failures;

        function new();
            world_seed = '0;
            gen_state  = '0;
            failures   = 0;
        endfunction

        static function logic [63:0] splitmix(logic [63:0] v);
            logic [63:0] z;
            z = v + GOLDEN_ADD;
            z = (z ^ (z >> 30)) * MIX_MUL_A;
            z = (z ^ (z >> 27)) * MIX_MUL_B;
            return z ^ (z >> 31);
        endfunction

        function logic [31:0] next_word();
            gen_state = splitmix(gen_state);
            return gen_state[63:32];
        endfunction

        function void write_register(int unsigned idx, logic [63:0] value);
            if (idx == REG_WORLD_SEED)
                world_seed = value;
        endfunction

        // Advance the generator for one accepted item; queue the draw it yields.
        function void note_item(in_item_t it);
            out_item_t   draw;
            logic [63:0] region;
            logic [31:0] w;
            draw = '0;
            case (it.kind)
                KIND_RESEED:
                begin
                    // out-of-range vertical index is dropped without touching state
                    if (it.sub_chunk_y < SUB_CHUNKS_DEF)
                    begin
                        region = world_seed;
                        region ^= it.tick_index * TICK_MUL;
                        region ^= {32'b0, it.chunk_x} * CX_MUL;
                        region ^= {32'b0, it.chunk_z} * CZ_MUL;
                        region ^= {60'b0, it.sub_chunk_y} * SY_MUL;
                        gen_state = splitmix(region);
                    end
                end
                KIND_POS:
                begin
                    draw.result_kind = RES_POS;
                    w = next_word();
                    draw.local_x = w[3:0];
                    w = next_word();
                    draw.local_y = w[3:0];
                    w = next_word();
                    draw.local_z = w[3:0];
                    pending_draws.push_back(draw);
                end
                KIND_WORD:
                begin
                    draw.result_kind = RES_WORD;
                    draw.random_word = next_word();
                    pending_draws.push_back(draw);
                end
                default:
                    ;
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_draws.size() == 0)
            begin
                $error("unexpected result: result_kind %0d random_word %h",
                       got.result_kind, got.random_word);
                failures++;
                return;
            end
            want = pending_draws.pop_front();
            if (got.result_kind !== want.result_kind)
            begin
                $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
                failures++;
            end
            if (got.local_x !== want.local_x)
            begin
                $error("local_x: expected %0d, got %0d", want.local_x, got.local_x);
                failures++;
            end
            if (got.local_y !== want.local_y)
            begin
                $error("local_y: expected %0d, got %0d", want.local_y, got.local_y);
                failures++;
            end
            if (got.local_z !== want.local_z)
            begin
                $error("local_z: expected %0d, got %0d", want.local_z, got.local_z);
                failures++;
            end
            if (got.random_word !== want.random_word)
            begin
                $error("random_word: expected %h, got %h", want.random_word, got.random_word);
                failures++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_draws.size();
        endfunction
    endclass

endpackage

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Top-level testbench for seeded_random_position_sampler: drives items and result
// ready with random gaps, and writes and reads the APB port. Needs srps_pkg, srps_stream_if, srps_tb_pkg.
module tb;
    import srps_pkg::*;
    import srps_tb_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned SETTLE_CYCLES   = 40;
    localparam int unsigned ITEMS_PER_PHASE = 150;
    localparam int unsigned PRESSURE_HOLD   = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    srps_stream_if #(.payload_t(in_item_t))  item_ch ();
    srps_stream_if #(.payload_t(out_item_t)) draw_ch ();

    seeded_random_position_sampler uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (item_ch),
        .out_ch  (draw_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cell_draw_tracker tracker;
    bit               src_idle_on;
    bit               sink_idle_on;
    int unsigned      long_hold;
    int unsigned      quiet_cycles = 0;

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort when no transfer happens on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (draw_ch.valid && draw_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL seeded_random_position_sampler");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: random stall before each transfer while sink idling is on, plus one long hold on request
    initial
    begin
        int unsigned stall;
        draw_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = sink_idle_on ? $urandom_range(0, 7) : 0;
            if (long_hold != 0)
            begin
                stall = long_hold;
                long_hold = 0;
            end
            if (stall != 0)
            begin
                draw_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            draw_ch.ready <= 1'b1;
            do @(posedge clk); while (!draw_ch.valid);
            tracker.check_result(draw_ch.payload);
        end
    end

    task automatic apb_write(int unsigned idx, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx << REG_IDX_LSB);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.write_register(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(int unsigned idx, output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(idx << REG_IDX_LSB);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_world_seed(logic [63:0] value);
        logic [APB_DATA_W-1:0] rd;
        apb_write(REG_WORLD_SEED, value);
        apb_read(REG_WORLD_SEED, rd);
        if (rd !== tracker.world_seed)
        begin
            $error("world_seed: expected %h, got %h", tracker.world_seed, rd);
            tracker.failures++;
        end
    endtask

    task automatic send_item(in_item_t it);
        int unsigned gap;
        gap = src_idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        do @(posedge clk); while (!item_ch.ready);
        tracker.note_item(it);
    endtask

    // Drop valid, let every queued draw arrive, then cover a trailing reseed
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic in_item_t fixed_item(logic [1:0] kind, logic [63:0] tick,
                                            logic [31:0] cx, logic [31:0] cz,
                                            logic [3:0] sy);
        in_item_t it;
        it.kind        = kind;
        it.tick_index  = tick;
        it.chunk_x     = cx;
        it.chunk_z     = cz;
        it.sub_chunk_y = sy;
        return it;
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t random_item(logic [1:0] kind);
        logic [63:0] tick;
        case ($urandom_range(0, 7))
            0: tick = '0;
            1: tick = '1;
            default: tick = {$urandom, $urandom};
        endcase
        return fixed_item(kind, tick, pick_coord(), pick_coord(), 4'($urandom_range(0, 15)));
    endfunction

    task automatic run_directed();
        // draws before any reseed (from the reset state on the first run), then a dropped kind
        send_item(fixed_item(KIND_POS, '0, '0, '0, 4'd0));
        send_item(fixed_item(KIND_WORD, '0, '0, '0, 4'd0));
        send_item(fixed_item(KIND_UNDEF, '1, '1, '1, 4'hF));
        send_item(fixed_item(KIND_RESEED, '0, '0, '0, 4'd0));
        send_item(fixed_item(KIND_POS, '0, '0, '0, 4'd0));
        send_item(fixed_item(KIND_RESEED, '1, 32'h7FFF_FFFF, 32'h8000_0000, 4'hF));
        send_item(fixed_item(KIND_WORD, '1, '1, '1, 4'hF));
        send_item(fixed_item(KIND_RESEED, '0, 32'h8000_0000, 32'h7FFF_FFFF, 4'hF));
        send_item(fixed_item(KIND_POS, '1, '1, '1, 4'hF));
        send_item(fixed_item(KIND_RESEED, '1, '1, '1, 4'd0));
        send_item(fixed_item(KIND_WORD, '0, '0, '0, 4'd0));
        send_item(fixed_item(KIND_POS, '0, '0, '0, 4'd0));
        // a dropped kind in mid-sequence must not disturb the state
        send_item(fixed_item(KIND_UNDEF, 64'h8000_0000_0000_0001, '0, '1, 4'd7));
        send_item(fixed_item(KIND_WORD, '0, '0, '0, 4'd0));
        send_item(fixed_item(KIND_RESEED, 64'h0123_4567_89AB_CDEF, 32'd1, 32'hFFFF_FFFE, 4'd8));
        send_item(fixed_item(KIND_POS, '0, '0, '0, 4'd0));
        send_item(fixed_item(KIND_POS, '0, '0, '0, 4'd0));
        send_item(fixed_item(KIND_WORD, '0, '0, '0, 4'd0));
    endtask

    // Mostly reseed-then-draws sequences; some draw runs continue the old state
    task automatic run_random(int unsigned count);
        int unsigned sent;
        int unsigned draws;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(random_item(KIND_UNDEF));
            if ($urandom_range(0, 6) != 0)
            begin
                send_item(random_item(KIND_RESEED));
                sent++;
            end
            draws = $urandom_range(1, 6);
            repeat (draws)
            begin
                send_item(random_item($urandom_range(0, 1) ? KIND_POS : KIND_WORD));
                sent++;
            end
        end
    endtask

    initial
    begin
        tracker = new();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        long_hold    = 0;
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        item_ch.valid   <= 1'b0;
        item_ch.payload <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_world_seed('0);
        run_directed();
        run_random(ITEMS_PER_PHASE);
        drain();

        // all-ones seed, no idling on either side; poke the unmapped register
        set_world_seed('1);
        apb_write(REG_UNMAPPED, {$urandom, $urandom});
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        run_directed();
        run_random(ITEMS_PER_PHASE);
        drain();

        // back-pressure: hold the result side while items keep coming
        set_world_seed(64'h8000_0000_0000_0001);
        sink_idle_on = 1'b1;
        long_hold    = PRESSURE_HOLD;
        run_random(ITEMS_PER_PHASE);
        drain();

        src_idle_on = 1'b1;
        set_world_seed({$urandom, $urandom});
        run_random(ITEMS_PER_PHASE);
        drain();

        set_world_seed({$urandom, $urandom});
        sink_idle_on = 1'b0;
        run_random(ITEMS_PER_PHASE);
        drain();

        if (tracker.failures == 0 && tracker.outstanding() == 0)
            $display("PASS seeded_random_position_sampler");
        else
            $display("FAIL seeded_random_position_sampler");
        $finish;
    end

endmodule
